FILE: rtl/core/ppc_pkg.sv
// ppc_pkg: shared types, codes and widths for the playback position controller
// used by ppc_rem_unit and playback_position_controller; no dependencies
`default_nettype none

package ppc_pkg;

   // field widths
   localparam int unsigned POS_W    = 31;
   localparam int unsigned RATE_W   = 16;
   localparam int unsigned DELTA_W  = 24;
   localparam int unsigned TARGET_W = 32;
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned RATE_FRAC = 8;

   // product of delta and rate, and the unnormalized new position
   localparam int unsigned PROD_W = DELTA_W + RATE_W;
   localparam int unsigned SUM_W  = TARGET_W + 2;

   // remainder unit: magnitude width and step counter
   localparam int unsigned MAG_W = 32;
   localparam int unsigned CNT_W = $clog2(MAG_W);

   // configuration port
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] REG_CLIP_LENGTH = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PLAY_RATE   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_LOOPING     = 2'd2;

   localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

   // command codes
   localparam logic [MODE_W-1:0] MODE_TICK      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PLAY      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PAUSE     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STOP      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SET_POS   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLIP_RST  = 3'd5;

   // beat widths
   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 72;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_SUM  = 6'b000100,
      ST_CHK  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } ctl_state_type;

   typedef enum logic [2:0] {
      DV_IDLE = 3'b001,
      DV_STEP = 3'b010,
      DV_FIX  = 3'b100
   } rem_state_type;

   typedef struct packed {
      logic start;
      logic negative;
   } rem_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_sts_type;

endpackage

`default_nettype wire

FILE: rtl/core/ppc_rem_unit.sv
// ppc_rem_unit: iterative floor-modulo, one restoring subtract per cycle
// depends on ppc_pkg
`default_nettype none

module ppc_rem_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ppc_pkg::rem_ctl_type          ctl,
   input  wire logic [ppc_pkg::MAG_W-1:0]     dividend_mag,
   input  wire logic [ppc_pkg::POS_W-1:0]     divisor,
   output      ppc_pkg::rem_sts_type          sts,
   output      logic [ppc_pkg::POS_W-1:0]     remainder
);

   ppc_pkg::rem_state_type state_ff, state_in;
   logic [ppc_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      done_ff, done_in;
   logic                      neg_ff, neg_in;
   logic [ppc_pkg::POS_W-1:0] rem_ff, rem_in;
   logic [ppc_pkg::POS_W-1:0] len_ff, len_in;
   logic [ppc_pkg::MAG_W-1:0] quo_ff, quo_in;

   logic [ppc_pkg::MAG_W-1:0] shifted;
   logic [ppc_pkg::MAG_W:0]   diff;

   // the shared subtractor
   assign shifted = {rem_ff, quo_ff[ppc_pkg::MAG_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, len_ff};

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      len_in   = len_ff;
      quo_in   = quo_ff;
      case (state_ff)
         ppc_pkg::DV_IDLE: begin
            if (ctl.start) begin
               quo_in   = dividend_mag;
               rem_in   = '0;
               len_in   = divisor;
               neg_in   = ctl.negative;
               count_in = ppc_pkg::CNT_W'(ppc_pkg::MAG_W - 1);
               state_in = ppc_pkg::DV_STEP;
            end
         end
         ppc_pkg::DV_STEP: begin
            rem_in   = diff[ppc_pkg::MAG_W] ? shifted[ppc_pkg::POS_W-1:0]
                                            : diff[ppc_pkg::POS_W-1:0];
            quo_in   = {quo_ff[ppc_pkg::MAG_W-2:0], 1'b0};
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ppc_pkg::DV_FIX;
            end
         end
         ppc_pkg::DV_FIX: begin
            // floor correction for a negative dividend
            if (neg_ff && (rem_ff != '0)) begin
               rem_in = len_ff - rem_ff;
            end
            done_in  = 1'b1;
            state_in = ppc_pkg::DV_IDLE;
         end
         default: begin
            state_in = ppc_pkg::DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppc_pkg::DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      len_ff   <= len_in;
      quo_ff   <= quo_in;
   end

   assign sts.busy  = (state_ff != ppc_pkg::DV_IDLE);
   assign sts.done  = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: rtl/core/playback_position_controller.sv
// playback position controller top level: command sequencer, position state
// depends on ppc_pkg and ppc_rem_unit
//
// sequence: accept the request beat, multiply, sum, check, done; a looping tick
//   or set position also waits in the remainder state (32 remainder steps)
// throughput: one command at a time, next request taken the cycle after commit
// the remainder unit's one-bit-per-cycle loop makes the looping case the longest
// reset: synchronous, active high; clears positions and flags, loads
//   clip_length 0, play_rate 1.0, looping off
`default_nettype none

module playback_position_controller (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // delta_time[23:0], target_position[55:24]
   input  wire logic [ppc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode[2:0]
   input  wire logic [ppc_pkg::MODE_W-1:0]        req_tuser,
   // response channel
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // position[30:0], last_position[61:31], is_playing[62], is_paused[63],
   // reached_end[64], wrapped[65], zero fill[71:66]
   output      logic [ppc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register write channel
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [ppc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [ppc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned POS_W  = ppc_pkg::POS_W;
   localparam int unsigned SUM_W  = ppc_pkg::SUM_W;
   localparam int unsigned PROD_W = ppc_pkg::PROD_W;

   // sequencer
   ppc_pkg::ctl_state_type state_ff, state_in;

   // configuration registers
   logic [POS_W-1:0]                  clip_len_ff, clip_len_in;
   logic signed [ppc_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic                              loop_ff, loop_in;

   // playback state
   logic [POS_W-1:0] cur_ff, cur_in;
   logic [POS_W-1:0] prev_ff, prev_in;
   logic             run_ff, run_in;
   logic             hold_ff, hold_in;

   // command held for the whole sequence
   logic [ppc_pkg::MODE_W-1:0]     mode_ff, mode_in;
   logic [ppc_pkg::DELTA_W-1:0]    delta_ff, delta_in;
   logic [ppc_pkg::TARGET_W-1:0]   target_ff, target_in;

   // datapath registers
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [SUM_W-1:0]  nt_ff, nt_in;
   logic signed [PROD_W:0]   mul_full;

   // response register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ppc_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // remainder unit
   ppc_pkg::rem_ctl_type      div_ctl;
   ppc_pkg::rem_sts_type      div_sts;
   logic [ppc_pkg::MAG_W-1:0] div_mag;
   logic [SUM_W-1:0]          nt_neg;
   logic [POS_W-1:0]          div_rem;

   // decode
   logic                    req_beat;
   logic                    commit;
   logic                    len_zero;
   logic                    rate_zero;
   logic                    tick_go;
   logic                    need_div;
   logic signed [SUM_W-1:0] len_ext;
   logic                    nt_ge_len;
   logic                    nt_le_zero;
   logic [POS_W-1:0]        nt_clamped;
   logic                    reached;
   logic                    wrapped;

   assign req_tready = (state_ff == ppc_pkg::ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign commit     = (state_ff == ppc_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   assign len_zero  = (clip_len_ff == '0);
   assign rate_zero = (rate_ff == '0);
   assign tick_go   = run_ff && !hold_ff;

   // a wrap needs the remainder unit for a moving tick or a set position
   assign need_div = !len_zero && loop_ff &&
                     (((mode_ff == ppc_pkg::MODE_TICK) && tick_go && !rate_zero) ||
                      (mode_ff == ppc_pkg::MODE_SET_POS));

   // delta is unsigned, rate signed Q8.8
   assign mul_full = $signed({1'b0, delta_ff}) * rate_ff;

   // magnitude of the new position for the remainder unit
   assign nt_neg  = '0 - nt_ff;
   assign div_mag = nt_ff[SUM_W-1] ? nt_neg[ppc_pkg::MAG_W-1:0]
                                   : nt_ff[ppc_pkg::MAG_W-1:0];
   assign div_ctl.start    = (state_ff == ppc_pkg::ST_CHK) && need_div;
   assign div_ctl.negative = nt_ff[SUM_W-1];

   ppc_rem_unit u_rem (
      .clock        (clock),
      .reset        (reset),
      .ctl          (div_ctl),
      .dividend_mag (div_mag),
      .divisor      (clip_len_ff),
      .sts          (div_sts),
      .remainder    (div_rem)
   );

   // compares against the clip ends
   assign len_ext    = $signed({{(SUM_W-POS_W){1'b0}}, clip_len_ff});
   assign nt_ge_len  = (nt_ff >= len_ext);
   assign nt_le_zero = nt_ff[SUM_W-1] || (nt_ff == '0);
   assign nt_clamped = nt_ff[SUM_W-1] ? '0 :
                       (nt_ff > len_ext) ? clip_len_ff : nt_ff[POS_W-1:0];

   // sequencer and command capture
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      delta_in  = delta_ff;
      target_in = target_ff;
      prod_in   = prod_ff;
      nt_in     = nt_ff;
      case (state_ff)
         ppc_pkg::ST_IDLE: begin
            if (req_beat) begin
               mode_in   = req_tuser;
               delta_in  = req_tdata[ppc_pkg::DELTA_W-1:0];
               target_in = req_tdata[ppc_pkg::DELTA_W +: ppc_pkg::TARGET_W];
               state_in  = ppc_pkg::ST_MUL;
            end
         end
         ppc_pkg::ST_MUL: begin
            prod_in  = mul_full[PROD_W-1:0];
            state_in = ppc_pkg::ST_SUM;
         end
         ppc_pkg::ST_SUM: begin
            // arithmetic shift by the rate fraction rounds toward minus infinity
            if (mode_ff == ppc_pkg::MODE_SET_POS) begin
               nt_in = $signed({{(SUM_W-ppc_pkg::TARGET_W){target_ff[ppc_pkg::TARGET_W-1]}},
                                target_ff});
            end else begin
               nt_in = $signed({{(SUM_W-POS_W){1'b0}}, cur_ff}) +
                       $signed({{(SUM_W-(PROD_W-ppc_pkg::RATE_FRAC)){prod_ff[PROD_W-1]}},
                                prod_ff[PROD_W-1:ppc_pkg::RATE_FRAC]});
            end
            state_in = ppc_pkg::ST_CHK;
         end
         ppc_pkg::ST_CHK: begin
            state_in = need_div ? ppc_pkg::ST_DIV : ppc_pkg::ST_DONE;
         end
         ppc_pkg::ST_DIV: begin
            if (div_sts.done) begin
               state_in = ppc_pkg::ST_DONE;
            end
         end
         ppc_pkg::ST_DONE: begin
            if (commit) begin
               state_in = ppc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ppc_pkg::ST_IDLE;
         end
      endcase
   end

   // command effect on the playback state, applied at commit
   always_comb begin
      cur_in  = cur_ff;
      prev_in = prev_ff;
      run_in  = run_ff;
      hold_in = hold_ff;
      reached = 1'b0;
      wrapped = 1'b0;
      case (mode_ff)
         ppc_pkg::MODE_TICK: begin
            if (tick_go) begin
               prev_in = cur_ff;
               if (len_zero) begin
                  // no clip loaded
                  cur_in  = '0;
                  run_in  = 1'b0;
                  hold_in = 1'b0;
                  reached = 1'b1;
               end else if (!rate_zero) begin
                  if (loop_ff) begin
                     wrapped = nt_ff[SUM_W-1] || nt_ge_len;
                     cur_in  = div_rem;
                  end else if (nt_ge_len) begin
                     // ran past the end
                     cur_in  = clip_len_ff;
                     run_in  = 1'b0;
                     hold_in = 1'b0;
                     reached = 1'b1;
                  end else if (nt_le_zero && rate_ff[ppc_pkg::RATE_W-1]) begin
                     // reverse play hit the start
                     cur_in  = '0;
                     run_in  = 1'b0;
                     hold_in = 1'b0;
                     reached = 1'b1;
                  end else begin
                     cur_in = nt_clamped;
                  end
               end
            end
         end
         ppc_pkg::MODE_PLAY: begin
            run_in  = !len_zero;
            hold_in = 1'b0;
         end
         ppc_pkg::MODE_PAUSE: begin
            if (run_ff) begin
               hold_in = 1'b1;
            end
         end
         ppc_pkg::MODE_STOP: begin
            run_in  = 1'b0;
            hold_in = 1'b0;
            prev_in = '0;
            cur_in  = '0;
         end
         ppc_pkg::MODE_SET_POS: begin
            prev_in = cur_ff;
            if (len_zero) begin
               cur_in = '0;
            end else if (loop_ff) begin
               cur_in = div_rem;
            end else begin
               cur_in = nt_clamped;
            end
         end
         ppc_pkg::MODE_CLIP_RST: begin
            prev_in = '0;
            cur_in  = '0;
            if (len_zero) begin
               run_in  = 1'b0;
               hold_in = 1'b0;
            end
         end
         default: begin
            // unused codes leave the state alone
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, wrapped, reached, hold_in, run_in, prev_in, cur_in};
      end
   end

   // register writes
   always_comb begin
      clip_len_in = clip_len_ff;
      rate_in     = rate_ff;
      loop_in     = loop_ff;
      if (csr_valid && csr_ready) begin
         case (csr_addr)
            ppc_pkg::REG_CLIP_LENGTH: clip_len_in = csr_wdata[POS_W-1:0];
            ppc_pkg::REG_PLAY_RATE:   rate_in     = $signed(csr_wdata[ppc_pkg::RATE_W-1:0]);
            ppc_pkg::REG_LOOPING:     loop_in     = csr_wdata[0];
            default: begin
               // writes past the register list are dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clip_len_ff  <= '0;
         rate_ff      <= $signed(ppc_pkg::RATE_RESET);
         loop_ff      <= 1'b0;
         cur_ff       <= '0;
         prev_ff      <= '0;
         run_ff       <= 1'b0;
         hold_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clip_len_ff  <= clip_len_in;
         rate_ff      <= rate_in;
         loop_ff      <= loop_in;
         if (commit) begin
            cur_ff  <= cur_in;
            prev_ff <= prev_in;
            run_ff  <= run_in;
            hold_ff <= hold_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      delta_ff    <= delta_in;
      target_ff   <= target_in;
      prod_ff     <= prod_in;
      nt_ff       <= nt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // register writes are always taken
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // paused only ever while playing
   a_hold_needs_run: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> run_ff)
      else $error("paused flag set while not playing");

   // an accepted command starts the multiply step
   a_beat_starts_mul: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ppc_pkg::ST_MUL))
      else $error("request beat did not start the sequence");

   // the remainder unit is only started when free
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_sts.busy)
      else $error("remainder unit started while busy");

   // a finished remainder is only seen while waiting for it
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ppc_pkg::ST_DIV))
      else $error("remainder done outside the wait state");

   // a new response comes only from a commit
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ppc_pkg::ST_DONE))
      else $error("response raised without a commit");
`endif

endmodule

`default_nettype wire

FILE: tb/ppc_checker.sv
// ppc_checker: watches the register, request and response channels of the
// playback position controller, predicts every response beat and compares it
// depends on ppc_pkg for field widths, command codes and register indexes
module ppc_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic [ppc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [ppc_pkg::MODE_W-1:0]        req_tuser,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [ppc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire logic                              csr_valid,
   input  wire logic                              csr_ready,
   input  wire logic [ppc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [ppc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int unsigned                            fail_count,
   output int unsigned                            pending_count
);
   import ppc_pkg::*;

   typedef struct {
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] last_position;
      logic             is_playing;
      logic             is_paused;
      logic             reached_end;
      logic             wrapped;
   } play_status_type;

   play_status_type expected_status[$];

   // register copies
   logic [POS_W-1:0]         clip_len;
   logic signed [RATE_W-1:0] rate_q88;
   logic                     looping_on;

   // position state
   logic [POS_W-1:0] cur_pos;
   logic [POS_W-1:0] prev_pos;
   logic             playing;
   logic             paused;

   // floor-modulo wrap or clamp into the clip
   function automatic logic [POS_W-1:0] fold_position(input longint t, input longint len,
                                                      input logic wrap);
      longint r;
      if (wrap) begin
         r = t % len;
         if (r < 0) r += len;
      end else if (t < 0) begin
         r = 0;
      end else if (t > len) begin
         r = len;
      end else begin
         r = t;
      end
      return r[POS_W-1:0];
   endfunction

   task automatic step_position(input logic [MODE_W-1:0] mode,
                                input logic [DELTA_W-1:0] delta,
                                input logic signed [TARGET_W-1:0] target,
                                output play_status_type status);
      longint len;
      longint stride;
      longint next_pos;
      logic   reached;
      logic   wrapped;
      len     = longint'(clip_len);
      reached = 1'b0;
      wrapped = 1'b0;
      case (mode)
         MODE_TICK: begin
            if (playing && !paused) begin
               prev_pos = cur_pos;
               if (len == 0) begin
                  cur_pos = '0;
                  playing = 1'b0;
                  paused  = 1'b0;
                  reached = 1'b1;
               end else if (rate_q88 != 0) begin
                  // Q8.8 rate, floor back to position format
                  stride   = (longint'(delta) * longint'(rate_q88)) >>> RATE_FRAC;
                  next_pos = longint'(cur_pos) + stride;
                  if (looping_on) begin
                     wrapped = (next_pos < 0 || next_pos >= len);
                     cur_pos = fold_position(next_pos, len, 1'b1);
                  end else if (next_pos >= len) begin
                     cur_pos = clip_len;
                     reached = 1'b1;
                     playing = 1'b0;
                     paused  = 1'b0;
                  end else if (next_pos <= 0 && rate_q88 < 0) begin
                     cur_pos = '0;
                     reached = 1'b1;
                     playing = 1'b0;
                     paused  = 1'b0;
                  end else begin
                     cur_pos = fold_position(next_pos, len, 1'b0);
                  end
               end
            end
         end
         MODE_PLAY: begin
            playing = (len != 0);
            paused  = 1'b0;
         end
         MODE_PAUSE: begin
            if (playing) paused = 1'b1;
         end
         MODE_STOP: begin
            playing  = 1'b0;
            paused   = 1'b0;
            prev_pos = '0;
            cur_pos  = '0;
         end
         MODE_SET_POS: begin
            prev_pos = cur_pos;
            if (len == 0) cur_pos = '0;
            else cur_pos = fold_position(longint'(target), len, looping_on);
         end
         MODE_CLIP_RST: begin
            prev_pos = '0;
            cur_pos  = '0;
            if (len == 0) begin
               playing = 1'b0;
               paused  = 1'b0;
            end
         end
         default: begin
            // spare codes leave everything alone
         end
      endcase
      status.position      = cur_pos;
      status.last_position = prev_pos;
      status.is_playing    = playing;
      status.is_paused     = paused;
      status.reached_end   = reached;
      status.wrapped       = wrapped;
   endtask

   task automatic flag_error(input string what, input logic [31:0] want, input logic [31:0] got);
      fail_count++;
      if (fail_count <= 10) $display("mismatch %s: expected %h got %h", what, want, got);
   endtask

   always @(posedge clock) begin : watch
      play_status_type want;
      play_status_type fresh;
      if (reset) begin
         clip_len   = '0;
         rate_q88   = RATE_RESET;
         looping_on = 1'b0;
         cur_pos    = '0;
         prev_pos   = '0;
         playing    = 1'b0;
         paused     = 1'b0;
         fail_count = 0;
         expected_status.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               REG_CLIP_LENGTH: clip_len   = csr_wdata[POS_W-1:0];
               REG_PLAY_RATE:   rate_q88   = csr_wdata[RATE_W-1:0];
               REG_LOOPING:     looping_on = csr_wdata[0];
               default: begin
               end
            endcase
         end
         // response first: a beat never answers a request taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status.size() == 0) begin
               flag_error("response with none expected", '0, rsp_tdata[31:0]);
            end else begin
               want = expected_status.pop_front();
               if (rsp_tdata[30:0] !== want.position)
                  flag_error("position", 32'(want.position), 32'(rsp_tdata[30:0]));
               if (rsp_tdata[61:31] !== want.last_position)
                  flag_error("last_position", 32'(want.last_position),
                             32'(rsp_tdata[61:31]));
               if (rsp_tdata[62] !== want.is_playing)
                  flag_error("is_playing", 32'(want.is_playing), 32'(rsp_tdata[62]));
               if (rsp_tdata[63] !== want.is_paused)
                  flag_error("is_paused", 32'(want.is_paused), 32'(rsp_tdata[63]));
               if (rsp_tdata[64] !== want.reached_end)
                  flag_error("reached_end", 32'(want.reached_end), 32'(rsp_tdata[64]));
               if (rsp_tdata[65] !== want.wrapped)
                  flag_error("wrapped", 32'(want.wrapped), 32'(rsp_tdata[65]));
               if (rsp_tdata[71:66] !== '0)
                  flag_error("fill", '0, 32'(rsp_tdata[71:66]));
            end
         end
         if (req_tvalid && req_tready) begin
            step_position(req_tuser, req_tdata[DELTA_W-1:0],
                          req_tdata[DELTA_W +: TARGET_W], fresh);
            expected_status.push_back(fresh);
         end
      end
      pending_count = expected_status.size();
   end

endmodule

FILE: tb/testbench.sv
// testbench: directed and random command streams for the playback position
// controller with random stalls on both channels; checking sits in ppc_checker
// depends on ppc_pkg, ppc_checker and the playback_position_controller rtl
module testbench;
   import ppc_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1650;
   localparam int unsigned PHASES       = 12;
   localparam int unsigned HOLD_CYCLES  = 400;   // long response hold-off
   localparam int unsigned DRAIN_CYCLES = 60;    // longer than a wrap through the remainder unit
   localparam longint      TIMEOUT      = 30_000_000;

   // spare command codes the block must ignore
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   localparam logic [POS_W-1:0]    LEN_MAX      = '1;
   localparam logic [POS_W-1:0]    ONE_SEC      = 31'h0001_0000;
   localparam logic [RATE_W-1:0]   RATE_MAX     = 16'h7FFF;
   localparam logic [RATE_W-1:0]   RATE_MIN     = 16'h8000;
   localparam logic [RATE_W-1:0]   RATE_REVERSE = 16'hFF00;
   localparam logic [RATE_W-1:0]   RATE_STILL   = 16'h0000;
   localparam logic [DELTA_W-1:0]  DELTA_MAX    = '1;
   localparam logic [TARGET_W-1:0] TARGET_MAX   = 32'h7FFF_FFFF;
   localparam logic [TARGET_W-1:0] TARGET_MIN   = 32'h8000_0000;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;   // delta_time[23:0], target_position[55:24]
   logic [MODE_W-1:0]       req_tuser  = '0;   // mode[2:0]
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b1;
   // position[30:0], last_position[61:31], is_playing[62], is_paused[63],
   // reached_end[64], wrapped[65], zero fill[71:66]
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   int unsigned fail_count;
   int unsigned pending_count;

   // idling controls shared by the sender and the receiver
   bit quiet;      // no stalls on either side
   bit hold_rsp;   // receiver holds off for HOLD_CYCLES

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   playback_position_controller i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   ppc_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // offer one command beat and wait until it is taken
   task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [DELTA_W-1:0] delta,
                           input logic [TARGET_W-1:0] target);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {target, delta};
      do @(posedge clock); while (!req_tready);
   endtask

   // sender drops valid and idles; n sets the length of the gap, zero skips it
   task automatic idle_gap(input int unsigned n);
      if (n > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // sender goes quiet until every response beat has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // only called with the block drained
   task automatic set_config(input logic [POS_W-1:0] len, input logic [RATE_W-1:0] rate,
                             input logic loop);
      write_reg(REG_CLIP_LENGTH, {1'b0, len});
      write_reg(REG_PLAY_RATE, {16'h0000, rate});
      write_reg(REG_LOOPING, {31'h0, loop});
   endtask

   // receiver: mostly ready, short and occasional long stalls, one long hold-off
   initial begin : rsp_side
      int unsigned stall;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (quiet || $urandom_range(0, 99) < 75) begin
            rsp_tready <= 1'b1;
         end else begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [POS_W-1:0]    len;
      logic [RATE_W-1:0]   rate;
      logic                loop;
      logic [MODE_W-1:0]   mode;
      logic [DELTA_W-1:0]  delta;
      logic [TARGET_W-1:0] target;
      int unsigned         pick;
      int unsigned         burst;
      quiet    = 1'b1;
      hold_rsp = 1'b0;
      burst    = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // reset settings, no clip loaded: play refused, everything else idle or zeroing
      send_cmd(MODE_PLAY, '0, '0);
      send_cmd(MODE_PAUSE, '0, '0);
      send_cmd(MODE_TICK, DELTA_MAX, '0);
      send_cmd(MODE_SET_POS, '0, TARGET_MAX);
      send_cmd(MODE_CLIP_RST, '0, '0);
      send_cmd(MODE_STOP, '0, '0);
      send_cmd(MODE_SPARE_LO, DELTA_MAX, TARGET_MIN);
      send_cmd(MODE_SPARE_HI, DELTA_MAX, TARGET_MAX);

      // clamped 100 s clip at unit rate: run off the end, clamp targets both ways
      wait_drained();
      set_config(POS_W'(100 * ONE_SEC), RATE_RESET, 1'b0);
      send_cmd(MODE_PLAY, '0, '0);
      send_cmd(MODE_TICK, DELTA_MAX, '0);
      send_cmd(MODE_SET_POS, '0, TARGET_MAX);
      send_cmd(MODE_SET_POS, '0, TARGET_MIN);
      send_cmd(MODE_PLAY, '0, '0);
      send_cmd(MODE_PAUSE, '0, '0);
      send_cmd(MODE_TICK, DELTA_W'(ONE_SEC), '0);        // paused, no motion
      send_cmd(MODE_PLAY, '0, '0);
      send_cmd(MODE_TICK, '0, '0);             // zero delta
      send_cmd(MODE_TICK, DELTA_W'(ONE_SEC), '0);

      // most negative rate: reverse into the start of the clip
      wait_drained();
      set_config(POS_W'(100 * ONE_SEC), RATE_MIN, 1'b0);
      send_cmd(MODE_TICK, 24'h1, '0);
      send_cmd(MODE_TICK, DELTA_MAX, '0);

      // looping short clip at the top rate: wrap on tick and on both target extremes
      wait_drained();
      set_config(POS_W'(3 * ONE_SEC), RATE_MAX, 1'b1);
      send_cmd(MODE_PLAY, '0, '0);
      send_cmd(MODE_TICK, DELTA_MAX, '0);
      send_cmd(MODE_SET_POS, '0, TARGET_MIN);
      send_cmd(MODE_SET_POS, '0, TARGET_MAX);

      // longest clip, zero rate: tick only moves last_position
      wait_drained();
      set_config(LEN_MAX, RATE_STILL, 1'b1);
      send_cmd(MODE_PLAY, '0, '0);
      send_cmd(MODE_TICK, DELTA_MAX, '0);

      // clip unloaded while playing: zero length tick stops and zeroes
      wait_drained();
      set_config('0, RATE_RESET, 1'b1);
      send_cmd(MODE_TICK, DELTA_W'(ONE_SEC), '0);
      send_cmd(MODE_CLIP_RST, '0, '0);

      // --- random part: a new setting per phase, state carried across ---
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case ($urandom_range(0, 11))
            0:          len = '0;
            1, 2:       len = POS_W'($urandom_range(1, 16));
            3, 4, 5, 6: len = POS_W'($urandom_range(ONE_SEC, 100 * ONE_SEC));
            7, 8:       len = POS_W'($urandom);
            9:          len = LEN_MAX;
            default:    len = POS_W'($urandom_range(ONE_SEC / 4, 4 * ONE_SEC));
         endcase
         case ($urandom_range(0, 9))
            0:       rate = RATE_RESET;
            1:       rate = RATE_REVERSE;
            2:       rate = RATE_MAX;
            3:       rate = RATE_MIN;
            4:       rate = RATE_STILL;
            5:       rate = RATE_W'($urandom_range(1, 64));
            6:       rate = RATE_W'(-$urandom_range(1, 64));
            default: rate = RATE_W'($urandom);
         endcase
         loop = 1'($urandom_range(0, 1));
         quiet = (p % 4 == 3);
         set_config(len, rate, loop);

         for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
            // mostly ticks so that play sequences get somewhere
            pick = $urandom_range(0, 99);
            if (pick < 50) mode = MODE_TICK;
            else if (pick < 64) mode = MODE_PLAY;
            else if (pick < 71) mode = MODE_PAUSE;
            else if (pick < 75) mode = MODE_STOP;
            else if (pick < 89) mode = MODE_SET_POS;
            else if (pick < 95) mode = MODE_CLIP_RST;
            else mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
            case ($urandom_range(0, 9))
               0:          delta = '0;
               1:          delta = DELTA_MAX;
               2, 3, 4:    delta = DELTA_W'($urandom_range(1, 16'hFFFF));
               5, 6:       delta = DELTA_W'($urandom_range(1, 24'h3_FFFF));
               default:    delta = DELTA_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0:       target = $urandom;
               1:       target = $urandom_range(0, 32'h00FF_FFFF);
               2:       target = -$urandom_range(1, 32'h00FF_FFFF);
               default: target = {1'b0, len} + $urandom_range(0, 2) - 1;  // around the end
            endcase

            // hold off the receiver while the sender keeps pushing
            if (p == 2 && i == 40) begin
               hold_rsp = 1'b1;
               burst    = 24;
            end
            // sender waits for the block to empty mid phase
            if (p == 5 && i == 70) wait_drained();

            send_cmd(mode, delta, target);
            if (burst > 0) begin
               burst--;
            end else if (!quiet) begin
               idle_gap(($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(0, 2));
            end
         end
      end

      // drain and let any stray beat show up
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
